[design/jfhp_pkg.sv]
// Package for the JPEG frame header parser: word types, parse phases and constants.
`default_nettype none
package jfhp_pkg;

  // Marker bytes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_SOF1   = 8'hC1;
  localparam logic [7:0] MARK_SOF2   = 8'hC2;

  // Result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // Countdown holds at most a segment length minus two
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_SOI      = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_BAD_HEAD = CNT_W'(3);

  typedef enum logic [10:0] {
    PH_SKIP  = 11'b00000000001,
    PH_MARK  = 11'b00000000010,
    PH_LENH  = 11'b00000000100,
    PH_LENL  = 11'b00000001000,
    PH_PREC  = 11'b00000010000,
    PH_HGT_H = 11'b00000100000,
    PH_HGT_L = 11'b00001000000,
    PH_WID_H = 11'b00010000000,
    PH_WID_L = 11'b00100000000,
    PH_COUNT = 11'b01000000000,
    PH_BAD   = 11'b10000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  sample_precision;
    logic [7:0]  component_count;
  } out_word_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] countdown;
    logic [7:0]       marker_code;
    logic [7:0]       length_high;
    logic [15:0]      held_width;
    logic [15:0]      held_height;
    logic [7:0]       held_precision;
    logic [7:0]       held_components;
    logic [1:0]       held_status;
    logic             decided;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:           PH_SKIP,
    countdown:       CNT_SOI,
    marker_code:     8'd0,
    length_high:     8'd0,
    held_width:      16'd0,
    held_height:     16'd0,
    held_precision:  8'd0,
    held_components: 8'd0,
    held_status:     ST_NOTFOUND,
    decided:         1'b0
  };

endpackage
`default_nettype wire

[design/jpeg_frame_header_parser.sv]
// Top level of the JPEG frame header parser: parse state, output register, checks.
// Takes one file byte per cycle while in_ready is high and gives one result word per file,
// registered, on the cycle after the byte flagged last is taken. The whole per-byte
// update is a single pass of the phase/countdown logic into the state registers, so
// in_ready stays high unless a finished result is waiting and out_ready is low. Bytes
// after a decision are still taken at full rate and ignored.
`default_nettype none
module jpeg_frame_header_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  jfhp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output jfhp_pkg::out_word_t  out_data
);
  import jfhp_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  out_word_t    result;
  logic         in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  jfhp_step u_step (
    .cur  (state),
    .word (in_data),
    .nxt  (state_next),
    .res  (result)
  );

  // Parse state advances on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) begin
      out_data <= result;
    end
  end

  // Checks
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_byte |=> state.phase == PH_SKIP && !state.decided &&
                                    state.countdown == CNT_SOI)
    else $error("parse did not restart after last word");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire && in_data.last_byte))
    else $error("result appeared without a last word");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_FOUND |->
      out_data.image_width == 16'd0 && out_data.image_height == 16'd0 &&
      out_data.sample_precision == 8'd0 && out_data.component_count == 8'd0)
    else $error("fields not cleared on failed parse");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_FOUND || out_data.status == ST_INVALID ||
                  out_data.status == ST_NOTFOUND)
    else $error("undefined status code");

  a_decided_hold: assert property (@(posedge clk) disable iff (rst)
    state.decided && in_fire && !in_data.last_byte |=> state.decided &&
                                                      $stable(state.held_status))
    else $error("decision changed before end of file");

endmodule
`default_nettype wire

[design/jfhp_step.sv]
// Per-byte next-state and result logic of the frame header parser.
`default_nettype none
module jfhp_step (
  input  jfhp_pkg::parse_state_t cur,
  input  jfhp_pkg::in_word_t     word,
  output jfhp_pkg::parse_state_t nxt,
  output jfhp_pkg::out_word_t    res
);
  import jfhp_pkg::*;

  logic [15:0]      seg_len;
  logic [CNT_W-1:0] bad_cnt;
  parse_state_t     walk;
  logic [1:0]       st;

  assign seg_len = {cur.length_high, word.data_byte};
  assign bad_cnt = (cur.countdown != '0) ? cur.countdown - 1'b1 : cur.countdown;

  // Walk the segment structure; nothing moves once a decision is held
  always_comb begin
    walk = cur;
    if (!cur.decided) begin
      case (cur.phase)
        PH_MARK: begin
          walk.marker_code = word.data_byte;
          walk.phase = PH_LENH;
        end
        PH_LENH: begin
          walk.length_high = word.data_byte;
          walk.phase = PH_LENL;
        end
        PH_LENL: begin
          if (cur.marker_code == MARK_EOI || cur.marker_code == MARK_SOS) begin
            walk.held_status = ST_NOTFOUND;
            walk.decided = 1'b1;
          end else if (cur.marker_code == MARK_SOF0 || cur.marker_code == MARK_SOF1 ||
                       cur.marker_code == MARK_SOF2) begin
            walk.phase = PH_PREC;
          end else if (seg_len >= 16'd2) begin
            walk.countdown = CNT_W'(seg_len - 16'd2);
            walk.phase = PH_SKIP;
          end else begin
            // a length under two puts the next segment start inside the length field
            walk.countdown = (seg_len == 16'd0) ? CNT_SOI : CNT_BAD_HEAD;
            walk.phase = PH_BAD;
          end
        end
        PH_PREC: begin
          walk.held_precision = word.data_byte;
          walk.phase = PH_HGT_H;
        end
        PH_HGT_H: begin
          walk.held_height = {word.data_byte, 8'd0};
          walk.phase = PH_HGT_L;
        end
        PH_HGT_L: begin
          walk.held_height = {cur.held_height[15:8], word.data_byte};
          walk.phase = PH_WID_H;
        end
        PH_WID_H: begin
          walk.held_width = {word.data_byte, 8'd0};
          walk.phase = PH_WID_L;
        end
        PH_WID_L: begin
          walk.held_width = {cur.held_width[15:8], word.data_byte};
          walk.phase = PH_COUNT;
        end
        PH_COUNT: begin
          walk.held_components = word.data_byte;
          walk.held_status = ST_FOUND;
          walk.decided = 1'b1;
        end
        PH_BAD: begin
          // wait for the rest of the bad segment head before reporting
          walk.countdown = bad_cnt;
          if (bad_cnt == '0) begin
            walk.held_status = ST_INVALID;
            walk.decided = 1'b1;
          end
        end
        default: begin
          // skipping: start bytes or a segment body, then expect 0xFF
          if (cur.countdown == '0) begin
            if (word.data_byte == MARK_PREFIX) begin
              walk.phase = PH_MARK;
            end else begin
              walk.phase = PH_BAD;
              walk.countdown = CNT_BAD_HEAD;
            end
          end else begin
            walk.countdown = cur.countdown - 1'b1;
          end
        end
      endcase
    end
  end

  // Result word; fields read zero unless the frame header was found
  always_comb begin
    st = walk.decided ? walk.held_status : ST_NOTFOUND;
    res.status           = st;
    res.image_width      = (st == ST_FOUND) ? walk.held_width : 16'd0;
    res.image_height     = (st == ST_FOUND) ? walk.held_height : 16'd0;
    res.sample_precision = (st == ST_FOUND) ? walk.held_precision : 8'd0;
    res.component_count  = (st == ST_FOUND) ? walk.held_components : 8'd0;
  end

  // The last byte closes the file and restarts the parse
  assign nxt = word.last_byte ? STATE_RESET : walk;

endmodule
`default_nettype wire

[tb/jfhp_checker.sv]
// Checker for the JPEG frame header parser: predicts the header word of each file and compares.
`timescale 1ns / 1ps
module jfhp_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  jfhp_pkg::in_word_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  jfhp_pkg::out_word_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  import jfhp_pkg::*;

  // Predicted parse state of the file in flight
  phase_t      cur_phase;
  logic [16:0] skip_count;
  logic [7:0]  seg_marker;
  logic [7:0]  seg_len_hi;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [7:0]  frame_precision;
  logic [7:0]  frame_comps;
  logic [1:0]  verdict;
  logic        settled;

  out_word_t header_q[$];
  int        fail_tally = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic restart_file();
    cur_phase       = PH_SKIP;
    skip_count      = 17'd2;
    seg_marker      = 8'd0;
    seg_len_hi      = 8'd0;
    frame_width     = 16'd0;
    frame_height    = 16'd0;
    frame_precision = 8'd0;
    frame_comps     = 8'd0;
    verdict         = ST_NOTFOUND;
    settled         = 1'b0;
  endtask

  task automatic settle(input logic [1:0] st);
    verdict = st;
    settled = 1'b1;
  endtask

  // Advance the parse by one file byte; on the last byte queue the header word
  task automatic parse_file_byte(input logic [7:0] b, input logic last);
    logic [15:0] seg_len;
    out_word_t   hdr;
    if (!settled) begin
      case (cur_phase)
        PH_MARK: begin
          seg_marker = b;
          cur_phase  = PH_LENH;
        end
        PH_LENH: begin
          seg_len_hi = b;
          cur_phase  = PH_LENL;
        end
        PH_LENL: begin
          if (seg_marker == MARK_EOI || seg_marker == MARK_SOS) begin
            settle(ST_NOTFOUND);
          end else if (seg_marker == MARK_SOF0 || seg_marker == MARK_SOF1 ||
                       seg_marker == MARK_SOF2) begin
            cur_phase = PH_PREC;
          end else begin
            seg_len = {seg_len_hi, b};
            if (seg_len >= 16'd2) begin
              skip_count = 17'(seg_len) - 17'd2;
              cur_phase  = PH_SKIP;
            end else begin
              // next segment would start inside the length field
              skip_count = (seg_len == 16'd0) ? 17'd2 : 17'd3;
              cur_phase  = PH_BAD;
            end
          end
        end
        PH_PREC: begin
          frame_precision = b;
          cur_phase       = PH_HGT_H;
        end
        PH_HGT_H: begin
          frame_height = {b, 8'd0};
          cur_phase    = PH_HGT_L;
        end
        PH_HGT_L: begin
          frame_height[7:0] = b;
          cur_phase         = PH_WID_H;
        end
        PH_WID_H: begin
          frame_width = {b, 8'd0};
          cur_phase   = PH_WID_L;
        end
        PH_WID_L: begin
          frame_width[7:0] = b;
          cur_phase        = PH_COUNT;
        end
        PH_COUNT: begin
          frame_comps = b;
          settle(ST_FOUND);
        end
        PH_BAD: begin
          // wait out the rest of the bad segment head
          if (skip_count != 17'd0) skip_count = skip_count - 17'd1;
          if (skip_count == 17'd0) settle(ST_INVALID);
        end
        default: begin
          if (skip_count == 17'd0) begin
            if (b == MARK_PREFIX) begin
              cur_phase = PH_MARK;
            end else begin
              cur_phase  = PH_BAD;
              skip_count = 17'd3;
            end
          end else begin
            skip_count = skip_count - 17'd1;
          end
        end
      endcase
    end
    if (last) begin
      hdr = '0;
      hdr.status = settled ? verdict : ST_NOTFOUND;
      if (hdr.status == ST_FOUND) begin
        hdr.image_width      = frame_width;
        hdr.image_height     = frame_height;
        hdr.sample_precision = frame_precision;
        hdr.component_count  = frame_comps;
      end
      header_q.push_back(hdr);
      restart_file();
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_tally++;
    end
  endtask

  // Compare a result word with the oldest predicted header
  task automatic check_header(input out_word_t got);
    out_word_t want;
    if (header_q.size() == 0) begin
      $display("%0t: unexpected result word, expected none, got %h", $time, got);
      fail_tally++;
    end else begin
      want = header_q.pop_front();
      report_field("status", 16'(want.status), 16'(got.status));
      report_field("image_width", want.image_width, got.image_width);
      report_field("image_height", want.image_height, got.image_height);
      report_field("sample_precision", 16'(want.sample_precision),
                   16'(got.sample_precision));
      report_field("component_count", 16'(want.component_count),
                   16'(got.component_count));
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_file();
      header_q.delete();
    end else begin
      if (in_valid && in_ready) parse_file_byte(in_data.data_byte, in_data.last_byte);
      if (out_valid && out_ready) check_header(out_data);
    end
    mismatches  <= fail_tally;
    outstanding <= header_q.size();
  end

endmodule

[tb/tb.sv]
// Testbench top for the JPEG frame header parser: clock, reset, file stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import jfhp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BYTES   = 660;
  localparam int MIN_FILES      = 30;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int mismatches;
  int outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int stuck_cycles = 0;

  logic [7:0] file_bytes[$];

  always #10 clk = ~clk;

  jpeg_frame_header_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  jfhp_checker hdr_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver: random back-pressure at the current stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 65;
        stall_pct = 0;
      end
      2: begin
        gap_pct   = 0;
        stall_pct = 65;
      end
      default: begin
        gap_pct   = 37;
        stall_pct = 37;
      end
    endcase
  endtask

  // Offer one word and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= b;
    in_data.last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endtask

  // Build a random file, mostly well-formed segments with random content
  task automatic make_file();
    int         kind;
    int         len_kind;
    int         cut;
    logic [7:0] code;
    logic [15:0] seg_len;
    file_bytes.delete();
    if ($urandom_range(9) == 0) begin
      add_noise(2);
    end else begin
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'hD8);
    end
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        // segment to be skipped
        do begin
          code = 8'($urandom);
        end while (code == MARK_SOF0 || code == MARK_SOF1 || code == MARK_SOF2 ||
                   code == MARK_EOI || code == MARK_SOS);
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(code);
        len_kind = $urandom_range(99);
        if (len_kind < 75) begin
          seg_len = 16'($urandom_range(2, 9));
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          add_noise(seg_len - 2);
        end else if (len_kind < 87) begin
          // length too short to cover itself
          seg_len = 16'($urandom_range(1));
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          add_noise($urandom_range(1, 4));
        end else begin
          seg_len = 16'($urandom);
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          add_noise($urandom_range(0, 4));
        end
      end else if (kind < 75) begin
        // frame header with random fields
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back(MARK_SOF0 + 8'($urandom_range(2)));
        if ($urandom_range(1)) begin
          file_bytes.push_back(8'h00);
          file_bytes.push_back(8'h11);
        end else begin
          add_noise(2);
        end
        add_noise(6);
      end else if (kind < 85) begin
        file_bytes.push_back(MARK_PREFIX);
        file_bytes.push_back($urandom_range(1) ? MARK_EOI : MARK_SOS);
        add_noise(2);
      end else if (kind < 93) begin
        // segment start that is not the prefix
        file_bytes.push_back(8'($urandom_range(254)));
        add_noise(3);
      end else begin
        add_noise($urandom_range(1, 4));
      end
    end
    add_noise($urandom_range(0, 3));
    // sometimes end the file early
    if ($urandom_range(99) < 20) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  initial begin
    int random_bytes;
    int files;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed files: lone last byte, all-ones frame header, bad start, end of image
    set_idling(0);
    file_bytes = '{8'h00};
    send_file();
    file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    file_bytes = '{8'hFF, 8'hD8, 8'h00, 8'h00, 8'h00, 8'h00};
    send_file();
    file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hD9, 8'h00, 8'h00};
    send_file();

    // One long skip segment ahead of a frame header
    file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE1, 8'h01, 8'h00};
    add_noise(254);
    file_bytes.push_back(MARK_PREFIX);
    file_bytes.push_back(MARK_SOF2);
    add_noise(8);
    send_file();

    // Random files across the idling phases
    random_bytes = 0;
    files = 0;
    while (random_bytes < RANDOM_BYTES || files < MIN_FILES) begin
      set_idling((random_bytes * 4) / RANDOM_BYTES);
      make_file();
      send_file();
      random_bytes += file_bytes.size();
      files++;
    end
    in_valid <= 1'b0;

    // Drain and decide
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
